### rtl/pcpt_pkg.sv
`default_nettype none
package pcpt_pkg;

  // Angle arithmetic in Q30 radians, carried in 40 bits through range reduction.
  localparam int ANG_W = 40;
  // CORDIC datapath width: Q30 values with headroom for gain and sign.
  localparam int CRD_W = 34;

  localparam logic signed [ANG_W-1:0] ANG_PI      = 40'sd3373259426;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 40'sd1686629713;
  localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 40'sd6746518852;
  localparam logic signed [ANG_W-1:0] ANG_FOUR_PI = 40'sd13493037704;
  localparam logic signed [ANG_W-1:0] ANG_3PI     = 40'sd10119778278;
  localparam logic signed [ANG_W-1:0] ANG_5PI     = 40'sd16866297130;

  localparam logic signed [CRD_W-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
  // 163 / 1024 approximates 1 / (2 pi) for the coarse turn count.
  localparam logic signed [17:0] TURN_RECIP = 18'sd163;

  typedef enum logic [1:0] {
    KIND_ELLIPSE = 2'd0,
    KIND_CIRCLE  = 2'd1,
    KIND_HELIX   = 2'd2,
    KIND_SPARE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    CFG_KIND     = 3'd0,
    CFG_CENTRE_X = 3'd1,
    CFG_CENTRE_Y = 3'd2,
    CFG_RADIUS_X = 3'd3,
    CFG_RADIUS_Y = 3'd4,
    CFG_PITCH    = 3'd5
  } cfg_index_t;

  // Values that ride alongside the CORDIC pipe.
  typedef struct packed {
    logic               neg;
    logic signed [31:0] pz;
    logic               ovz;
    logic signed [31:0] tz;
  } side_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0:  r = 30'd843314857;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043837;
      5'd3:  r = 30'd133525159;
      5'd4:  r = 30'd67021687;
      5'd5:  r = 30'd33543516;
      5'd6:  r = 30'd16775851;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194283;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048576;
      5'd11: r = 30'd524288;
      5'd12: r = 30'd262144;
      5'd13: r = 30'd131072;
      5'd14: r = 30'd65536;
      5'd15: r = 30'd32768;
      5'd16: r = 30'd16384;
      5'd17: r = 30'd8192;
      5'd18: r = 30'd4096;
      5'd19: r = 30'd2048;
      5'd20: r = 30'd1024;
      5'd21: r = 30'd512;
      5'd22: r = 30'd256;
      5'd23: r = 30'd128;
      5'd24: r = 30'd64;
      5'd25: r = 30'd32;
      5'd26: r = 30'd16;
      5'd27: r = 30'd8;
      5'd28: r = 30'd4;
      5'd29: r = 30'd2;
      5'd30: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  // Clamp to signed 32 bits; bit 32 of the result flags a clamp.
  function automatic logic [32:0] sat32(input logic signed [39:0] v);
    logic [32:0] r;
    if (v > 40'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -40'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/parametric_curve_point_tangent_core.sv
`default_nettype none
// Point and tangent of an ellipse, circle or helix at curve parameter t
// (Q8.24 radians); coordinates, radii and pitch are Q16.16. The block is a
// fully pipelined datapath: one item enters per cycle while the pipe is not
// held, and each result passes through six stages of range reduction and
// helix arithmetic, one stage per CORDIC rotation, and three stages of sign
// fix, radius multiply and round/saturate. The whole pipe advances together;
// it holds while a result waits on the output and out_ready is low. Write
// configuration only while no item is in flight.
module parametric_curve_point_tangent_core
  import pcpt_pkg::*;
#(
  parameter int CORDIC_STEPS = 24
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration write port
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  // input item channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] t_angle,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      point_x,
  output logic signed [31:0]      point_y,
  output logic signed [31:0]      point_z,
  output logic signed [31:0]      tangent_x,
  output logic signed [31:0]      tangent_y,
  output logic signed [31:0]      tangent_z,
  output logic                    overflow
);

  // ---------------- configuration registers ----------------
  kind_t              curve_kind;
  logic signed [31:0] centre_x, centre_y, pitch;
  logic [30:0]        radius_x, radius_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_kind <= KIND_ELLIPSE;
      centre_x   <= '0;
      centre_y   <= '0;
      radius_x   <= 31'd65536;
      radius_y   <= 31'd65536;
      pitch      <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_KIND:     curve_kind <= kind_t'(cfg_data[1:0]);
        CFG_CENTRE_X: centre_x   <= cfg_data;
        CFG_CENTRE_Y: centre_y   <= cfg_data;
        CFG_RADIUS_X: radius_x   <= cfg_data[30:0];
        CFG_RADIUS_Y: radius_y   <= cfg_data[30:0];
        CFG_PITCH:    pitch      <= cfg_data;
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  logic is_helix, shared_radius;
  assign is_helix      = (curve_kind == KIND_HELIX);
  assign shared_radius = (curve_kind == KIND_CIRCLE) || (curve_kind == KIND_HELIX);

  // The whole pipe advances together unless the output holds a result that
  // has not been taken.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // ---------------- stage 1: capture t ----------------
  logic               v1;
  logic signed [31:0] t1;

  // ---------------- stage 2: shifted angle, helix products ----------------
  logic                    v2;
  logic signed [ANG_W-1:0] n2, n_next;
  logic signed [63:0]      p2, tzp2, p_next, tzp_next;

  assign n_next   = (ANG_W'(t1) <<< 6) + ANG_PI;
  assign p_next   = 64'(pitch) * 64'(t1);
  assign tzp_next = 64'(pitch) * 64'(signed'({2'b00, INV_TWO_PI_Q32}));

  // ---------------- stage 3: coarse turn count, split helix product --------
  logic                    v3;
  logic signed [ANG_W-1:0] n3;
  logic signed [7:0]       k3;
  logic signed [63:0]      phc3;
  logic [31:0]             lo3;
  logic signed [31:0]      tz3;
  logic signed [17:0]      kprod;
  logic signed [63:0]      phc_next, tz_round;
  logic [63:0]             plc;

  assign kprod    = 18'(signed'(n2[ANG_W-1:30])) * TURN_RECIP;
  assign phc_next = 64'(signed'(p2[63:32])) * 64'(signed'({2'b00, INV_TWO_PI_Q32}));
  assign plc      = {32'b0, p2[31:0]} * {34'b0, INV_TWO_PI_Q32};
  assign tz_round = tzp2 + 64'sd2147483648;

  // ---------------- stage 4: remainder, helix z ----------------
  logic                    v4;
  logic signed [ANG_W-1:0] r4, r_next;
  side_t                   s4;
  logic signed [63:0]      zsum;
  logic [32:0]             zsat;

  assign r_next = n3 - (ANG_W'(k3) * ANG_TWO_PI);
  assign zsum   = phc3 + 64'(lo3) + 64'sd8388608;
  assign zsat   = sat32(zsum[63:24]);

  // ---------------- stage 5: pick the remainder in [-pi, pi) ----------------
  logic                    v5;
  logic signed [ANG_W-1:0] w5, w_next;
  side_t                   s5;

  always_comb begin
    priority if (r4 < 0) begin
      w_next = r4 + ANG_PI;
    end else if (r4 < ANG_TWO_PI) begin
      w_next = r4 - ANG_PI;
    end else if (r4 < ANG_FOUR_PI) begin
      w_next = r4 - ANG_3PI;
    end else begin
      w_next = r4 - ANG_5PI;
    end
  end

  // ---------------- stage 6: fold into [-pi/2, pi/2] ----------------
  logic                    v6;
  logic signed [CRD_W-1:0] z6;
  side_t                   s6;
  logic signed [ANG_W-1:0] f_next;
  logic                    neg_next;

  always_comb begin
    priority if (w5 > ANG_HALF_PI) begin
      f_next   = w5 - ANG_PI;
      neg_next = 1'b1;
    end else if (w5 < -ANG_HALF_PI) begin
      f_next   = w5 + ANG_PI;
      neg_next = 1'b1;
    end else begin
      f_next   = w5;
      neg_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1      <= t_angle;
      n2      <= n_next;
      p2      <= p_next;
      tzp2    <= tzp_next;
      n3      <= n2;
      k3      <= kprod[17:10];
      phc3    <= phc_next;
      lo3     <= plc[63:32];
      tz3     <= tz_round[63:32];
      r4      <= r_next;
      s4      <= '{neg: 1'b0, pz: zsat[31:0], ovz: zsat[32], tz: tz3};
      w5      <= w_next;
      s5      <= s4;
      z6      <= f_next[CRD_W-1:0];
      s6      <= '{neg: neg_next, pz: s5.pz, ovz: s5.ovz, tz: s5.tz};
    end
  end

  // ---------------- CORDIC rotation pipe ----------------
  logic                    vc;
  logic signed [CRD_W-1:0] xc, yc;
  side_t                   sc;

  pcpt_cordic #(
    .STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v6),
    .in_z     (z6),
    .in_side  (s6),
    .out_valid(vc),
    .out_x    (xc),
    .out_y    (yc),
    .out_side (sc)
  );

  // ---------------- sign fix: cos, sin, -sin ----------------
  logic                    vn;
  logic signed [CRD_W-1:0] cos_n, sin_n, nsin_n;
  side_t                   sn;

  // ---------------- radius products ----------------
  logic                    vm;
  logic signed [65:0]      px_m, py_m, tx_m, ty_m;
  side_t                   sm;
  logic signed [31:0]      rx_s, ry_s;

  assign rx_s = signed'({1'b0, radius_x});
  assign ry_s = shared_radius ? signed'({1'b0, radius_x}) : signed'({1'b0, radius_y});

  // ---------------- round, add centre, saturate ----------------
  logic signed [65:0] px_r, py_r, tx_r, ty_r;
  logic [32:0]        px_s, py_s, tx_s, ty_s;

  assign px_r = px_m + 66'sd536870912;
  assign py_r = py_m + 66'sd536870912;
  assign tx_r = tx_m + 66'sd536870912;
  assign ty_r = ty_m + 66'sd536870912;
  assign px_s = sat32(40'(signed'(px_r[65:30])) + 40'(centre_x));
  assign py_s = sat32(40'(signed'(py_r[65:30])) + 40'(centre_y));
  assign tx_s = sat32(40'(signed'(tx_r[65:30])));
  assign ty_s = sat32(40'(signed'(ty_r[65:30])));

  always_ff @(posedge clk) begin
    if (rst) begin
      vn        <= 1'b0;
      vm        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vn        <= vc;
      vm        <= vn;
      out_valid <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_n     <= sc.neg ? -xc : xc;
      sin_n     <= sc.neg ? -yc : yc;
      nsin_n    <= sc.neg ? yc : -yc;
      sn        <= sc;
      px_m      <= 66'(rx_s) * 66'(cos_n);
      py_m      <= 66'(ry_s) * 66'(sin_n);
      tx_m      <= 66'(rx_s) * 66'(nsin_n);
      ty_m      <= 66'(ry_s) * 66'(cos_n);
      sm        <= sn;
      point_x   <= px_s[31:0];
      point_y   <= py_s[31:0];
      tangent_x <= tx_s[31:0];
      tangent_y <= ty_s[31:0];
      point_z   <= is_helix ? sm.pz : '0;
      tangent_z <= is_helix ? sm.tz : '0;
      overflow  <= px_s[32] | py_s[32] | tx_s[32] | ty_s[32] | (is_helix & sm.ovz);
    end
  end

endmodule
`default_nettype wire

### rtl/pcpt_cordic.sv
`default_nettype none
module pcpt_cordic
  import pcpt_pkg::*;
#(
  parameter int STEPS = 24
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire logic signed [CRD_W-1:0] in_z,
  input  wire side_t                   in_side,
  output logic                         out_valid,
  output logic signed [CRD_W-1:0]      out_x,
  output logic signed [CRD_W-1:0]      out_y,
  output side_t                        out_side
);

  logic signed [CRD_W-1:0] xs [STEPS];
  logic signed [CRD_W-1:0] ys [STEPS];
  logic signed [CRD_W-1:0] zs [STEPS];
  side_t                   sd [STEPS];
  logic [STEPS-1:0]        vld;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [CRD_W-1:0] xp, yp, zp, x_next, y_next, z_next, ang;
    side_t sp;
    logic  vp;

    if (i == 0) begin : g_first
      assign xp = GAIN_Q30;
      assign yp = '0;
      assign zp = in_z;
      assign sp = in_side;
      assign vp = in_valid;
    end else begin : g_rest
      assign xp = xs[i-1];
      assign yp = ys[i-1];
      assign zp = zs[i-1];
      assign sp = sd[i-1];
      assign vp = vld[i-1];
    end

    assign ang = signed'(CRD_W'(atan_q30(5'(i))));

    always_comb begin
      if (zp >= 0) begin
        x_next = xp - (yp >>> i);
        y_next = yp + (xp >>> i);
        z_next = zp - ang;
      end else begin
        x_next = xp + (yp >>> i);
        y_next = yp - (xp >>> i);
        z_next = zp + ang;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vp;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xs[i] <= x_next;
        ys[i] <= y_next;
        zs[i] <= z_next;
        sd[i] <= sp;
      end
    end
  end

  assign out_valid = vld[STEPS-1];
  assign out_x     = xs[STEPS-1];
  assign out_y     = ys[STEPS-1];
  assign out_side  = sd[STEPS-1];

endmodule
`default_nettype wire

### tb/tb_parametric_curve_point_tangent_core.sv
`timescale 1ns / 100ps
module tb_parametric_curve_point_tangent_core
  import pcpt_pkg::*;
();

  localparam int STEPS = 24;
  // Angle constants in Q30 radians
  localparam longint Q30_PI      = 64'sd3373259426;
  localparam longint Q30_HALF_PI = 64'sd1686629713;
  localparam longint Q30_TWO_PI  = 64'sd6746518852;
  localparam longint CORDIC_K    = 64'sd652032874;
  localparam longint RECIP_2PI   = 64'sd683565276;
  // pi/2 in the Q8.24 input format
  localparam int T_QUARTER = 26353589;
  // indexes past the register list; writes there must be dropped
  localparam logic [2:0] CFG_UNUSED_6 = 3'd6;
  localparam logic [2:0] CFG_UNUSED_7 = 3'd7;

  localparam longint ARCTAN [0:23] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};

  typedef struct {
    logic signed [31:0] px, py, pz, tx, ty, tz;
    logic               ov;
  } curve_sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] t_angle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] point_x, point_y, point_z, tangent_x, tangent_y, tangent_z;
  logic overflow;

  // shadow copy of the block's registers
  kind_t  sh_kind = KIND_ELLIPSE;
  longint sh_cx = 0, sh_cy = 0, sh_rx = 65536, sh_ry = 65536, sh_pitch = 0;

  logic signed [31:0] angle_q[$];     // angles waiting for the driver
  curve_sample_t      sample_q[$];    // predicted samples, oldest first
  bit  steady_in = 1'b0, steady_out = 1'b0, long_hold = 1'b0;
  int  errors = 0, n_in = 0, n_out = 0, n_ovf = 0;

  parametric_curve_point_tangent_core #(.CORDIC_STEPS(STEPS)) i_dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .t_angle,
    .out_valid, .out_ready, .point_x, .point_y, .point_z,
    .tangent_x, .tangent_y, .tangent_z, .overflow
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic longint clamp32(longint v, inout bit ov);
    if (v > 64'sd2147483647) begin
      ov = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ov = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Point and tangent of the configured curve at angle t
  function automatic curve_sample_t eval_curve(logic signed [31:0] t);
    longint a, n, k, z, x, y, dx, dy, c, s, ry, p, ph, pl, lo;
    bit flip, ov;
    curve_sample_t r;
    ov = 1'b0;
    flip = 1'b0;
    // reduce to [-pi, pi), then fold into [-pi/2, pi/2]
    a = longint'(t) * 64;
    n = a + Q30_PI;
    k = n / Q30_TWO_PI;
    if (n % Q30_TWO_PI < 0) k--;
    z = a - k * Q30_TWO_PI;
    if (z > Q30_HALF_PI) begin
      z -= Q30_PI;
      flip = 1'b1;
    end else if (z < -Q30_HALF_PI) begin
      z += Q30_PI;
      flip = 1'b1;
    end
    x = CORDIC_K;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARCTAN[i];
      end else begin
        x += dx; y -= dy; z += ARCTAN[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    ry = (sh_kind == KIND_CIRCLE || sh_kind == KIND_HELIX) ? sh_rx : sh_ry;
    r.px = 32'(clamp32(((sh_rx * c + (64'sd1 <<< 29)) >>> 30) + sh_cx, ov));
    r.py = 32'(clamp32(((ry * s + (64'sd1 <<< 29)) >>> 30) + sh_cy, ov));
    r.tx = 32'(clamp32((sh_rx * (-s) + (64'sd1 <<< 29)) >>> 30, ov));
    r.ty = 32'(clamp32((ry * c + (64'sd1 <<< 29)) >>> 30, ov));
    r.pz = '0;
    r.tz = '0;
    if (sh_kind == KIND_HELIX) begin
      // split pitch*t so the 1/(2 pi) multiply stays within 64 bits
      p  = sh_pitch * longint'(t);
      ph = p >>> 32;
      pl = p & 64'hFFFF_FFFF;
      lo = (pl * RECIP_2PI) >>> 32;
      r.pz = 32'(clamp32((ph * RECIP_2PI + lo + (64'sd1 <<< 23)) >>> 24, ov));
      r.tz = 32'(clamp32((sh_pitch * RECIP_2PI + (64'sd1 <<< 31)) >>> 32, ov));
    end
    r.ov = ov;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // Driver: offer queued angles, predict each one on its transfer
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        sample_q.insert(sample_q.size(), eval_curve(t_angle));
        n_in++;
      end
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (angle_q.size() > 0) begin
        in_valid <= 1'b1;
        t_angle <= angle_q.pop_front();
        in_gap = steady_in ? 0 : $urandom_range(0, 17);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result transfer against the oldest prediction
  int out_gap = 0, held = 0;
  always @(posedge clk) begin
    curve_sample_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_out++;
        if (overflow) n_ovf++;
        if (sample_q.size() == 0) begin
          errors++;
          $display("%0t: result with no prediction waiting, actual x=%h y=%h",
                   $time, point_x, point_y);
        end else begin
          e = sample_q.pop_front();
          check_field("point_x", e.px, point_x);
          check_field("point_y", e.py, point_y);
          check_field("point_z", e.pz, point_z);
          check_field("tangent_x", e.tx, tangent_x);
          check_field("tangent_y", e.ty, tangent_y);
          check_field("tangent_z", e.tz, tangent_z);
          check_field("overflow", {31'd0, e.ov}, {31'd0, overflow});
        end
        out_gap = steady_out ? 0 : $urandom_range(0, 17);
      end
      // one long hold-off so the pipe fills and stalls its input
      if (long_hold && held < 400) begin
        held++;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_KIND:     sh_kind  = kind_t'(val[1:0]);
      CFG_CENTRE_X: sh_cx    = longint'(signed'(val));
      CFG_CENTRE_Y: sh_cy    = longint'(signed'(val));
      CFG_RADIUS_X: sh_rx    = longint'(val[30:0]);
      CFG_RADIUS_Y: sh_ry    = longint'(val[30:0]);
      CFG_PITCH:    sh_pitch = longint'(signed'(val));
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_curve(kind_t k, logic [31:0] cx, logic [31:0] cy,
                           logic [31:0] rx, logic [31:0] ry, logic [31:0] pt);
    write_reg(CFG_KIND, {30'd0, k});
    write_reg(CFG_CENTRE_X, cx);
    write_reg(CFG_CENTRE_Y, cy);
    write_reg(CFG_RADIUS_X, rx);
    write_reg(CFG_RADIUS_Y, ry);
    write_reg(CFG_PITCH, pt);
  endtask

  // Hold until every predicted sample has come back, then let the pipe drain
  task automatic wait_drained();
    while (angle_q.size() > 0 || in_valid || sample_q.size() > 0) @(posedge clk);
    repeat (STEPS + 16) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_angle();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 422000000) - 211000000;
      2: return $signed($urandom_range(0, 16)) * T_QUARTER - 8 * T_QUARTER
                + $urandom_range(0, 8) - 4;
      default: return 32'd1 << $urandom_range(0, 31);
    endcase
  endfunction

  task automatic queue_directed();
    logic [31:0] pts [$];
    pts = '{32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF,
            T_QUARTER, T_QUARTER + 1, -T_QUARTER, -T_QUARTER - 1,
            2 * T_QUARTER, 2 * T_QUARTER - 1, -2 * T_QUARTER, -2 * T_QUARTER + 1,
            4 * T_QUARTER, -4 * T_QUARTER, 3 * T_QUARTER, 32'h5555_5555,
            32'hAAAA_AAAA, 32'h0100_0000};
    foreach (pts[i]) angle_q.insert(angle_q.size(), pts[i]);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // defaults after reset: unit ellipse at the origin
    queue_directed();
    wait_drained();

    for (int ph = 1; ph <= 9; ph++) begin
      case (ph)
        1: set_curve(KIND_ELLIPSE, 32'h000A_0000, 32'hFFEC_0000, 32'h0003_8000,
                     32'h0000_4000, 32'h0001_0000);
        2: set_curve(KIND_CIRCLE, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        3: set_curve(KIND_HELIX, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'd0, 32'h7FFF_FFFF);
        4: set_curve(KIND_HELIX, 32'h0001_0000, 32'hFFFF_0000, 32'h0010_0000,
                     32'h0001_0000, 32'h8000_0000);
        5: set_curve(KIND_SPARE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h0123_4567);
        default: begin
          set_curve(kind_t'($urandom_range(0, 3)), $urandom, $urandom,
                    $urandom >> $urandom_range(0, 16), $urandom >> $urandom_range(0, 16),
                    $urandom);
          write_reg(CFG_UNUSED_6, $urandom);
          write_reg(CFG_UNUSED_7, $urandom);
        end
      endcase
      steady_in  = (ph % 2 == 1);
      steady_out = (ph % 3 == 0);
      // phase four: sender streams back to back while the receiver holds off
      if (ph == 4) begin
        steady_in = 1'b1;
        long_hold = 1'b1;
      end
      if (ph == 3 || ph == 9) queue_directed();
      repeat (150) angle_q.insert(angle_q.size(), rand_angle());
      // the sender then pauses here until every prediction is matched
      wait_drained();
    end

    $display("Checked %0d samples from %0d angles over ellipse, circle, helix and spare kind;",
             n_out, n_in);
    $display("%0d of them saturated, with back-pressure and idle gaps on both channels.",
             n_ovf);
    if (errors == 0 && sample_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule
